FILE: hw/rtl/sweeping_tap_pitch_delay_macros.svh
// Assertion helpers used by stpd_sweep.
`ifndef SWEEPING_TAP_PITCH_DELAY_MACROS_SVH
`define SWEEPING_TAP_PITCH_DELAY_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge while out of reset.
`define STPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Implication checked on every rising clock edge while out of reset.
`define STPD_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define STPD_ASSERT(lbl, prop, msg)
`define STPD_ASSERT_IMPL(lbl, pre, post, msg)
`endif

`endif

FILE: hw/rtl/stpd_pkg.sv
package stpd_pkg;

  typedef logic [15:0] sample_t;
  typedef logic [7:0]  pwm_byte_t;

  localparam sample_t     SIGN_FLIP   = 16'h8000;
  localparam pwm_byte_t   PWM_FLIP    = 8'h80;
  localparam int unsigned TURN_MARGIN = 4;
  localparam int unsigned FALL_STEP   = 2;

endpackage

FILE: hw/rtl/sweeping_tap_pitch_delay.sv
// Channel  | Dir | tdata (low bit up)              | Meaning
// s_axis   | in  | [15:0] adc_word                 | converter word, one per tick
// m_axis   | out | [7:0] pwm_high, [15:8] pwm_low  | held sample as PWM bytes
//
// One transfer per cycle unless the output stalls; each input yields one output.
// The dual-port ring does one write and one tap read per transfer.
// Reset: ring reads as zero until written (fill tracking), held sample 0x8000.
// A stalled output stalls input only while the output register is full.
module sweeping_tap_pitch_delay #(
  parameter int RING_DEPTH = 512
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] adc_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [7:0] pwm_high, [15:8] pwm_low
);
  import stpd_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic          adv;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic          rd_hit;
  sample_t       held;
  logic          m_valid_q;
  pwm_byte_t     pwm_high_q;
  pwm_byte_t     pwm_low_q;

  assign s_axis_tready = !m_valid_q || m_axis_tready;
  assign adv           = s_axis_tvalid && s_axis_tready;

  stpd_sweep #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_sweep (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .wr_addr_o(wr_addr),
    .rd_addr_o(rd_addr),
    .rd_hit_o (rd_hit)
  );

  stpd_ring #(
    .RING_DEPTH(RING_DEPTH),
    .AW        (AW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .wr_addr_i(wr_addr),
    .wr_data_i(s_axis_tdata ^ SIGN_FLIP),
    .rd_addr_i(rd_addr),
    .rd_hit_i (rd_hit),
    .held_o   (held)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pwm_high_q <= held[15:8] ^ PWM_FLIP;
      pwm_low_q  <= held[7:0];
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {pwm_low_q, pwm_high_q};

endmodule

FILE: hw/rtl/stpd_sweep.sv
`include "sweeping_tap_pitch_delay_macros.svh"

// Write pointer, sweeping tap offset and fill tracking.
module stpd_sweep #(
  parameter int RING_DEPTH = 512,
  parameter int AW         = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  output logic [AW-1:0] wr_addr_o,
  output logic [AW-1:0] rd_addr_o,
  output logic          rd_hit_o
);
  import stpd_pkg::*;

  localparam logic [AW:0]   DEPTH   = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(RING_DEPTH - 1);
  localparam logic [AW-1:0] OFF_TOP = AW'(RING_DEPTH - TURN_MARGIN);
  localparam logic [AW-1:0] OFF_BOT = AW'(TURN_MARGIN);
  localparam logic [AW-1:0] FALL    = AW'(FALL_STEP);

  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] off_q, off_d;
  logic          rising_q, rising_d;
  logic          full_q, full_d;
  logic [AW:0]   tap_sum;
  logic [AW:0]   tap_wrap;

  always_comb begin
    wp_d   = (wp_q == LAST) ? '0 : wp_q + 1'b1;
    full_d = full_q | (wp_q == LAST);
  end

  // tap = (new write position + offset) mod depth
  always_comb begin
    tap_sum  = {1'b0, wp_d} + {1'b0, off_q};
    tap_wrap = (tap_sum >= DEPTH) ? tap_sum - DEPTH : tap_sum;
  end

  assign wr_addr_o = wp_q;
  assign rd_addr_o = tap_wrap[AW-1:0];
  // entries are filled in address order until the first wrap
  assign rd_hit_o  = full_d | (tap_wrap[AW-1:0] < wp_d);

  always_comb begin
    rising_d = rising_q;
    off_d    = off_q;
    if (rising_q) begin
      if (off_q >= OFF_TOP) begin
        rising_d = 1'b0;
        off_d    = off_q - 1'b1;
      end else begin
        off_d = off_q + 1'b1;
      end
    end else begin
      if (off_q <= OFF_BOT) begin
        rising_d = 1'b1;
        off_d    = (off_q != '0) ? off_q - 1'b1 : '0;
      end else begin
        off_d = off_q - FALL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      off_q    <= '0;
      rising_q <= 1'b0;
      full_q   <= 1'b0;
    end else if (adv_i) begin
      wp_q     <= wp_d;
      off_q    <= off_d;
      rising_q <= rising_d;
      full_q   <= full_d;
    end
  end

  `STPD_ASSERT(a_off_range, off_q <= OFF_TOP, "tap offset above upper turn")
  `STPD_ASSERT(a_no_clash, !adv_i || (rd_addr_o != wr_addr_o), "tap read hits write slot")
  `STPD_ASSERT_IMPL(a_hold, !adv_i, $stable(wp_q) && $stable(off_q), "state moved without transfer")
  `STPD_ASSERT_IMPL(a_full_sticky, full_q, full_q, "fill flag dropped")

endmodule

FILE: hw/rtl/stpd_ring.sv
// Sample ring: one write and one registered tap read per transfer.
module stpd_ring #(
  parameter int RING_DEPTH = 512,
  parameter int AW         = 9
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  stpd_pkg::sample_t wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  input  logic             rd_hit_i,
  output stpd_pkg::sample_t held_o
);
  import stpd_pkg::*;

  sample_t mem [RING_DEPTH];
  sample_t rd_q;
  logic    first_q;
  logic    hit_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mem[wr_addr_i] <= wr_data_i;
      rd_q           <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      hit_q   <= 1'b0;
    end else if (adv_i) begin
      first_q <= 1'b0;
      hit_q   <= rd_hit_i;
    end
  end

  // never-written slots read as zero
  assign held_o = first_q ? SIGN_FLIP : (hit_q ? rd_q : '0);

endmodule
